// ===== sv/spid_pkg.sv =====
// Shared widths, register codes and stage word types for the speed PID block.
package spid_pkg;

  localparam int SPEED_W   = 16;
  localparam int DRIVE_W   = 16;
  localparam int GAIN_W    = 20;
  localparam int THR_W     = 16;
  localparam int ILIM_W    = 20;
  localparam int OLIM_W    = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  localparam int ERR_W     = SPEED_W + 1;
  localparam int INT_W     = 22;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int P_W       = GAIN_W + ERR_W;
  localparam int I_W       = GAIN_W + INT_W;
  localparam int D_W       = GAIN_W + DIFF_W;
  localparam int SUM_W     = I_W + 2;
  localparam int FRAC_BITS = 12;
  localparam int FLOOR_W   = SUM_W - FRAC_BITS;
  localparam int DEADBAND  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_SEP_THR  = 3'd3,
    REG_INT_LIM  = 3'd4,
    REG_OUT_LIM  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic        [THR_W-1:0]  separation_threshold;
    logic        [ILIM_W-1:0] integral_limit;
    logic        [OLIM_W-1:0] output_limit;
  } cfg_t;

  // error stage word
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [INT_W-1:0]  integ;
    logic signed [DIFF_W-1:0] diff;
    logic                     dead;
  } err_word_t;

  // product stage word
  typedef struct packed {
    logic signed [P_W-1:0] p_term;
    logic signed [I_W-1:0] i_term;
    logic signed [D_W-1:0] d_term;
    logic                  dead;
  } prod_word_t;

endpackage

// ===== sv/spid_regs.sv =====
// Configuration register file for the speed PID block.
module spid_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [spid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spid_pkg::CFG_DAT_W-1:0]   cfg_data,
  output spid_pkg::cfg_t                   cfg
);

  spid_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_write) begin
      case (spid_pkg::reg_idx_t'(cfg_index))
        spid_pkg::REG_GAIN_P: begin
          regs.gain_p <= signed'(cfg_data[spid_pkg::GAIN_W-1:0]);
        end
        spid_pkg::REG_GAIN_I: begin
          regs.gain_i <= signed'(cfg_data[spid_pkg::GAIN_W-1:0]);
        end
        spid_pkg::REG_GAIN_D: begin
          regs.gain_d <= signed'(cfg_data[spid_pkg::GAIN_W-1:0]);
        end
        spid_pkg::REG_SEP_THR: begin
          regs.separation_threshold <= cfg_data[spid_pkg::THR_W-1:0];
        end
        spid_pkg::REG_INT_LIM: begin
          regs.integral_limit <= cfg_data[spid_pkg::ILIM_W-1:0];
        end
        spid_pkg::REG_OUT_LIM: begin
          regs.output_limit <= cfg_data[spid_pkg::OLIM_W-1:0];
        end
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== sv/spid_err.sv =====
// Error stage: forms the error, updates integral and last error, registers the word.
module spid_err (
  input  logic                               clk,
  input  logic                               rst,
  input  spid_pkg::cfg_t                     cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [spid_pkg::SPEED_W-1:0] set_speed,
  input  logic signed [spid_pkg::SPEED_W-1:0] measured_speed,
  output logic                               out_valid,
  input  logic                               out_ready,
  output spid_pkg::err_word_t                out_word
);

  localparam int ERR_W  = spid_pkg::ERR_W;
  localparam int INT_W  = spid_pkg::INT_W;
  localparam int DIFF_W = spid_pkg::DIFF_W;

  logic signed [INT_W-1:0] integral_sum;
  logic signed [INT_W-1:0] integral_sum_next;
  logic signed [ERR_W-1:0] previous_error;
  logic                    valid;
  spid_pkg::err_word_t     word;

  logic signed [ERR_W-1:0] err;
  logic        [ERR_W-1:0] err_mag;
  logic                    sep;
  logic signed [INT_W-1:0] int_acc;
  logic signed [INT_W-1:0] lim;
  logic                    accept;

  assign in_ready = !valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    err     = ERR_W'(set_speed) - ERR_W'(measured_speed);
    err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    sep     = err_mag <= ERR_W'(cfg.separation_threshold);
    int_acc = integral_sum + (sep ? INT_W'(err) : INT_W'(0));
    lim     = signed'(INT_W'(cfg.integral_limit));
    // clamp on every word, integrated or not
    if (int_acc > lim) begin
      integral_sum_next = lim;
    end else if (int_acc < -lim) begin
      integral_sum_next = -lim;
    end else begin
      integral_sum_next = int_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
      valid          <= 1'b0;
    end else begin
      if (in_ready) begin
        valid <= in_valid;
      end
      if (accept) begin
        integral_sum   <= integral_sum_next;
        previous_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word.err   <= err;
      word.integ <= integral_sum_next;
      word.diff  <= DIFF_W'(err) - DIFF_W'(previous_error);
      word.dead  <= err_mag <= ERR_W'(spid_pkg::DEADBAND);
    end
  end

  assign out_valid = valid;
  assign out_word  = word;

endmodule

// ===== sv/spid_mult.sv =====
// Product stage: the three gain multiplications, registered.
module spid_mult (
  input  logic                 clk,
  input  logic                 rst,
  input  spid_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spid_pkg::err_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output spid_pkg::prod_word_t out_word
);

  localparam int P_W = spid_pkg::P_W;
  localparam int I_W = spid_pkg::I_W;
  localparam int D_W = spid_pkg::D_W;

  logic                 valid;
  spid_pkg::prod_word_t word;

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word.p_term <= P_W'(cfg.gain_p) * P_W'(in_word.err);
      word.i_term <= I_W'(cfg.gain_i) * I_W'(in_word.integ);
      word.d_term <= D_W'(cfg.gain_d) * D_W'(in_word.diff);
      word.dead   <= in_word.dead;
    end
  end

  assign out_valid = valid;
  assign out_word  = word;

endmodule

// ===== sv/spid_out.sv =====
// Output stage: sum, floor, deadband and saturation into the result register.
module spid_out (
  input  logic                               clk,
  input  logic                               rst,
  input  spid_pkg::cfg_t                     cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  spid_pkg::prod_word_t               in_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [spid_pkg::DRIVE_W-1:0] drive
);

  localparam int SUM_W   = spid_pkg::SUM_W;
  localparam int FLOOR_W = spid_pkg::FLOOR_W;
  localparam int DRIVE_W = spid_pkg::DRIVE_W;

  logic                      valid;
  logic signed [DRIVE_W-1:0] drive_reg;
  logic signed [DRIVE_W-1:0] drive_next;

  logic signed [SUM_W-1:0]   sum;
  logic signed [FLOOR_W-1:0] floored;
  logic signed [FLOOR_W-1:0] lim;
  logic signed [FLOOR_W-1:0] sat;

  always_comb begin
    sum     = SUM_W'(in_word.p_term) + SUM_W'(in_word.i_term) + SUM_W'(in_word.d_term);
    // dropping the fraction bits of a two's complement value floors it
    floored = signed'(sum[SUM_W-1:spid_pkg::FRAC_BITS]);
    lim     = signed'(FLOOR_W'(cfg.output_limit));
    if (floored > lim) begin
      sat = lim;
    end else if (floored < -lim) begin
      sat = -lim;
    end else begin
      sat = floored;
    end
    drive_next = in_word.dead ? DRIVE_W'(0) : sat[DRIVE_W-1:0];
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      drive_reg <= drive_next;
    end
  end

  assign out_valid = valid;
  assign drive     = drive_reg;

endmodule

// ===== sv/speed_pid_with_integral_separation.sv =====
// Speed PID with integral separation: an accepted word is registered in turn in the error/state,
// product and output stages before drive valid. Throughput one word per cycle when out_ready is
// not stalling the pipe; each stage holds one word and moves it on when the next stage has room.
// Integral and last error update in the error stage, so back-to-back words chain.
// Synchronous reset clears config registers, integral, last error and stage valids, not stage data.
module speed_pid_with_integral_separation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [spid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spid_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [spid_pkg::SPEED_W-1:0] set_speed,
  input  logic signed [spid_pkg::SPEED_W-1:0] measured_speed,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [spid_pkg::DRIVE_W-1:0] drive
);

  spid_pkg::cfg_t       cfg;
  spid_pkg::err_word_t  err_word;
  spid_pkg::prod_word_t prod_word;
  logic                 err_valid;
  logic                 err_ready;
  logic                 prod_valid;
  logic                 prod_ready;

  spid_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spid_err u_err (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .set_speed      (set_speed),
    .measured_speed (measured_speed),
    .out_valid      (err_valid),
    .out_ready      (err_ready),
    .out_word       (err_word)
  );

  spid_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_word   (err_word),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_word  (prod_word)
  );

  spid_out u_out (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_word   (prod_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive)
  );

endmodule

// ===== bench/tb_speed_pid_with_integral_separation.sv =====
// Self-checking testbench for the speed PID block with integral separation.
module tb_speed_pid_with_integral_separation;

  localparam int CFG_IDX_W = spid_pkg::CFG_IDX_W;
  localparam int CFG_DAT_W = spid_pkg::CFG_DAT_W;
  localparam int SPEED_W   = spid_pkg::SPEED_W;
  localparam int DRIVE_W   = spid_pkg::DRIVE_W;
  localparam int GAIN_W    = spid_pkg::GAIN_W;
  localparam int THR_W     = spid_pkg::THR_W;
  localparam int ILIM_W    = spid_pkg::ILIM_W;
  localparam int OLIM_W    = spid_pkg::OLIM_W;
  localparam int INT_W     = spid_pkg::INT_W;
  localparam int ERR_W     = spid_pkg::ERR_W;
  localparam int FRAC_BITS = spid_pkg::FRAC_BITS;
  localparam int DEADBAND  = spid_pkg::DEADBAND;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int WORDS_PER_CFG = 110;
  localparam int CFGS_PER_PASS = 5;

  // indexes past the last register; the block must ignore writes to them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DAT_W-1:0]       data;
    logic signed [SPEED_W-1:0]  tgt;
    logic signed [SPEED_W-1:0]  meas;
    bit                         typed;
    logic signed [DRIVE_W-1:0]  drive;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DAT_W-1:0]       cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SPEED_W-1:0]  set_speed = '0;
  logic signed [SPEED_W-1:0]  measured_speed = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [DRIVE_W-1:0]  drive;

  // controller settings and state as the block should hold them
  logic signed [GAIN_W-1:0]   kp, ki, kd;
  logic [THR_W-1:0]           sep_thr;
  logic [ILIM_W-1:0]          int_lim;
  logic [OLIM_W-1:0]          out_lim;
  logic signed [INT_W-1:0]    integ_acc;
  logic signed [ERR_W-1:0]    prev_err;

  logic signed [DRIVE_W-1:0]  pending_drives[$];
  logic signed [DRIVE_W-1:0]  oldest_drive;
  int                         mismatch_count = 0;
  int                         stall_cycles = 0;
  int                         send_idle_pct = 12;
  int                         recv_idle_pct = 65;

  stim_row_t dir_rows [40] = '{
    '{ROW_WORD, '0, '0,  32767, -32768, 1'b1, 0},
    '{ROW_WORD, '0, '0, -32768,  32767, 1'b1, 0},
    '{ROW_WORD, '0, '0,      0,      0, 1'b1, 0},
    '{ROW_WORD, '0, '0,      3,      0, 1'b1, 0},
    '{ROW_CFG, spid_pkg::REG_GAIN_P, 20'd4096,  0, 0, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_OUT_LIM, 20'd32767, 0, 0, 1'b0, 0},
    '{ROW_WORD, '0, '0,    100,      0, 1'b1, 100},
    '{ROW_WORD, '0, '0,      0,    100, 1'b1, -100},
    '{ROW_WORD, '0, '0,      3,      0, 1'b1, 3},
    '{ROW_WORD, '0, '0,      2,      0, 1'b1, 0},
    '{ROW_WORD, '0, '0,     -2,      0, 1'b1, 0},
    '{ROW_WORD, '0, '0,  32767, -32768, 1'b1, 32767},
    '{ROW_WORD, '0, '0, -32768,  32767, 1'b1, -32767},
    '{ROW_CFG, spid_pkg::REG_GAIN_P, 20'h80000, 0, 0, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_GAIN_I, 20'h7FFFF, 0, 0, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_GAIN_D, 20'h7FFFF, 0, 0, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_SEP_THR, 20'h0FFFF, 0, 0, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_INT_LIM, 20'hFFFFF, 0, 0, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_OUT_LIM, 20'd1000, 0, 0, 1'b0, 0},
    '{ROW_CFG, REG_SPARE_LO, 20'h12345, 0, 0, 1'b0, 0},
    '{ROW_CFG, REG_SPARE_HI, 20'hFFFFF, 0, 0, 1'b0, 0},
    '{ROW_WORD, '0, '0,  32767, -32768, 1'b0, 0},
    '{ROW_WORD, '0, '0,  32767, -32768, 1'b0, 0},
    '{ROW_WORD, '0, '0, -32768,  32767, 1'b0, 0},
    '{ROW_WORD, '0, '0,      1,      0, 1'b1, 0},
    '{ROW_WORD, '0, '0,  -1000,   1000, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_GAIN_P, 20'd0, 0, 0, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_GAIN_D, 20'd0, 0, 0, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_GAIN_I, 20'd4096, 0, 0, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_INT_LIM, 20'd100, 0, 0, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_SEP_THR, 20'd10, 0, 0, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_OUT_LIM, 20'd32767, 0, 0, 1'b0, 0},
    '{ROW_WORD, '0, '0,     20,      0, 1'b0, 0},
    '{ROW_WORD, '0, '0,     10,      0, 1'b0, 0},
    '{ROW_WORD, '0, '0,    -10,      0, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_INT_LIM, 20'd0, 0, 0, 1'b0, 0},
    '{ROW_WORD, '0, '0,     10,      0, 1'b1, 0},
    '{ROW_CFG, spid_pkg::REG_OUT_LIM, 20'd0, 0, 0, 1'b0, 0},
    '{ROW_CFG, spid_pkg::REG_GAIN_P, 20'd4096, 0, 0, 1'b0, 0},
    '{ROW_WORD, '0, '0,    500,      0, 1'b1, 0}
  };

  speed_pid_with_integral_separation uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .set_speed      (set_speed),
    .measured_speed (measured_speed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive          (drive)
  );

  always #4 clk = ~clk;

  // Work out the drive for one word and advance the integral and last error.
  function automatic logic signed [DRIVE_W-1:0] pid_drive(
    input logic signed [SPEED_W-1:0] tgt,
    input logic signed [SPEED_W-1:0] meas
  );
    longint e, e_mag, acc, ilim, olim, sum, d;
    e     = longint'(tgt) - longint'(meas);
    e_mag = (e < 0) ? -e : e;
    acc   = longint'(integ_acc);
    ilim  = longint'(int_lim);
    olim  = longint'(out_lim);
    if (e_mag <= longint'(sep_thr))
      acc = acc + e;
    if (acc > ilim)
      acc = ilim;
    else if (acc < -ilim)
      acc = -ilim;
    sum = longint'(kp) * e + longint'(ki) * acc + longint'(kd) * (e - longint'(prev_err));
    integ_acc = acc[INT_W-1:0];
    prev_err  = e[ERR_W-1:0];
    if (e_mag <= DEADBAND) begin
      d = 0;
    end else begin
      d = sum >>> FRAC_BITS;
      if (d > olim)
        d = olim;
      else if (d < -olim)
        d = -olim;
    end
    return d[DRIVE_W-1:0];
  endfunction

  // Draw a pair of speeds whose difference is err (magnitude capped at full span).
  function automatic void pair_for_error(
    input int err,
    output logic signed [SPEED_W-1:0] tgt,
    output logic signed [SPEED_W-1:0] meas
  );
    int e_mag, base;
    e_mag = (err < 0) ? -err : err;
    if (e_mag > 65535)
      e_mag = 65535;
    base = -32768 + int'($urandom_range(65535 - e_mag));
    if (err >= 0) begin
      meas = base[SPEED_W-1:0];
      tgt  = 16'(base + e_mag);
    end else begin
      tgt  = base[SPEED_W-1:0];
      meas = 16'(base + e_mag);
    end
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_gain();
    int g;
    case ($urandom_range(7))
      0: g = -524288;
      1: g = 524287;
      2: g = 0;
      3, 4: g = int'($urandom_range(32767)) - 16384;
      5: g = int'($urandom_range(20'hFFFFF));
      default: g = int'($urandom_range(8191)) - 4096;
    endcase
    return g[CFG_DAT_W-1:0];
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      spid_pkg::REG_GAIN_P:  kp = data;
      spid_pkg::REG_GAIN_I:  ki = data;
      spid_pkg::REG_GAIN_D:  kd = data;
      spid_pkg::REG_SEP_THR: sep_thr = data[THR_W-1:0];
      spid_pkg::REG_INT_LIM: int_lim = data[ILIM_W-1:0];
      spid_pkg::REG_OUT_LIM: out_lim = data[OLIM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(
    input logic signed [SPEED_W-1:0] tgt,
    input logic signed [SPEED_W-1:0] meas,
    input bit typed,
    input logic signed [DRIVE_W-1:0] typed_drive
  );
    logic signed [DRIVE_W-1:0] predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    set_speed      <= tgt;
    measured_speed <= meas;
    do @(posedge clk); while (!in_ready);
    predicted = pid_drive(tgt, meas);
    pending_drives.push_back(typed ? typed_drive : predicted);
  endtask

  task automatic random_settings();
    wait_drained();
    write_reg(spid_pkg::REG_GAIN_P, pick_gain());
    write_reg(spid_pkg::REG_GAIN_I, pick_gain());
    write_reg(spid_pkg::REG_GAIN_D, pick_gain());
    case ($urandom_range(4))
      0: write_reg(spid_pkg::REG_SEP_THR, 20'd0);
      1: write_reg(spid_pkg::REG_SEP_THR, 20'h0FFFF);
      2, 3: write_reg(spid_pkg::REG_SEP_THR, 20'($urandom_range(64)));
      default: write_reg(spid_pkg::REG_SEP_THR, 20'($urandom_range(16'hFFFF)));
    endcase
    case ($urandom_range(4))
      0: write_reg(spid_pkg::REG_INT_LIM, 20'd0);
      1: write_reg(spid_pkg::REG_INT_LIM, 20'hFFFFF);
      2, 3: write_reg(spid_pkg::REG_INT_LIM, 20'($urandom_range(2000)));
      default: write_reg(spid_pkg::REG_INT_LIM, 20'($urandom_range(20'hFFFFF)));
    endcase
    case ($urandom_range(7))
      0: write_reg(spid_pkg::REG_OUT_LIM, 20'd0);
      1, 2: write_reg(spid_pkg::REG_OUT_LIM, 20'h07FFF);
      default: write_reg(spid_pkg::REG_OUT_LIM, 20'($urandom_range(15'h7FFF)));
    endcase
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, 20'($urandom));
  endtask

  task automatic random_word();
    logic signed [SPEED_W-1:0] tgt, meas;
    int err;
    case ($urandom_range(9))
      0: begin
        tgt  = 16'($urandom);
        meas = 16'($urandom);
      end
      1: begin
        tgt  = $urandom_range(1) ? 16'sh7FFF : ($urandom_range(1) ? 16'sh8000 : 16'sh0000);
        meas = $urandom_range(1) ? 16'sh7FFF : ($urandom_range(1) ? 16'sh8000 : 16'sh0000);
      end
      2, 3, 4, 5: begin
        pair_for_error(int'($urandom_range(80)) - 40, tgt, meas);
      end
      6: begin
        // land on either side of the separation threshold
        err = int'(sep_thr) + int'($urandom_range(1));
        pair_for_error($urandom_range(1) ? err : -err, tgt, meas);
      end
      default: begin
        tgt  = 16'(int'($urandom_range(4000)) - 2000);
        meas = 16'(int'($urandom_range(4000)) - 2000);
      end
    endcase
    send_word(tgt, meas, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        $error("drive: no word expected, actual %0d", drive);
        mismatch_count++;
      end else begin
        oldest_drive = pending_drives.pop_front();
        if (drive !== oldest_drive) begin
          $error("drive: expected %0d, actual %0d", oldest_drive, drive);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    kp = '0; ki = '0; kd = '0;
    sep_thr = '0; int_lim = '0; out_lim = '0;
    integ_acc = '0; prev_err = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_word(dir_rows[i].tgt, dir_rows[i].meas, dir_rows[i].typed, dir_rows[i].drive);
      end
    end

    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin send_idle_pct = 12; recv_idle_pct = 65; end
        1: begin send_idle_pct = 65; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < CFGS_PER_PASS; seg++) begin
        random_settings();
        repeat (WORDS_PER_CFG) random_word();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
